[rtl/accumulator_iterative_alu_assert.svh]
// Assertion macros for the accumulating iterative ALU.
// Included by the top level; expects signals clk and rst in scope.
`ifndef ACCUMULATOR_ITERATIVE_ALU_ASSERT_SVH
`define ACCUMULATOR_ITERATIVE_ALU_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define AIA_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aia assertion failed");

// Next-cycle implication, disabled while reset is high
`define AIA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aia assertion failed");

`endif

[rtl/aia_pkg.sv]
// Shared types and command codes for the accumulating iterative ALU.
// No dependencies; used by the channel interfaces and the top level.
package aia_pkg;

  // Fixed width of the operand and result fields on the channels
  localparam int FieldWidth = 32;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_ADD = 3'd0;
  localparam cmd_t CMD_SUB = 3'd1;
  localparam cmd_t CMD_MUL = 3'd2;
  localparam cmd_t CMD_DIV = 3'd3;
  localparam cmd_t CMD_MOD = 3'd4;
  localparam cmd_t CMD_POW = 3'd5;

endpackage

[rtl/aia_req_if.sv]
// Command channel of the accumulating iterative ALU (valid/ready).
// Depends on aia_pkg for the command type and field width.
interface aia_req_if;
  import aia_pkg::*;

  logic                         valid;
  logic                         ready;
  cmd_t                         command;
  logic signed [FieldWidth-1:0] left_value;
  logic signed [FieldWidth-1:0] right_value;
  logic                         use_previous;

  modport source (output valid, command, left_value, right_value, use_previous,
                  input ready);
  modport sink   (input valid, command, left_value, right_value, use_previous,
                  output ready);
endinterface

[rtl/aia_rsp_if.sv]
// Result channel of the accumulating iterative ALU (valid/ready).
// Depends on aia_pkg for the field width.
interface aia_rsp_if;
  import aia_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [FieldWidth-1:0] result;
  logic                         error;

  modport source (output valid, result, error, input ready);
  modport sink   (input valid, result, error, output ready);
endinterface

[rtl/accumulator_iterative_alu.sv]
// Accumulating iterative integer ALU, top level.
// Depends on aia_pkg, aia_req_if, aia_rsp_if, aia_addsub and the assert header.
//
// Usage: one command transaction on req (command, left_value, right_value,
// use_previous) gives one transaction on rsp (result, error). With
// use_previous set, the last successful result replaces left_value.
// All arithmetic wraps at DATA_WIDTH bits; operands are sign-extended or cut
// from 32 bits, results sign-extended or cut back to 32 bits.
// How each command is worked out, with W = DATA_WIDTH:
//   add, subtract, special cases, unused codes: directly, with no iteration
//   multiply: one shift-add step per multiplier bit
//   divide, modulus: one restoring step per dividend bit, W steps in all
//   power: square-and-multiply over the exponent bits; every square and every
//     multiply runs through the same bit-serial shift-add loop
// Every arithmetic step uses the single adder/subtractor that they share.
// req.ready is high only while no command is in work; the next command may
// be taken while a finished result still waits in the rsp register.
// If rsp is stalled, a newly finished result waits until the register frees.
// Divide or modulus with a non-positive divisor that cannot end returns
// error = 1, result = 0 and leaves the stored result untouched.
// Reset (rst, synchronous) clears the stored result and drops rsp.valid.
module accumulator_iterative_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  aia_req_if.sink   req,
  aia_rsp_if.source rsp
);
  import aia_pkg::*;

`include "accumulator_iterative_alu_assert.svh"

  localparam int W    = DATA_WIDTH;
  localparam int CntW = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_PWR, S_FINISH} state_t;
  typedef enum logic [1:0] {RET_OUT, RET_PACC, RET_PSQ} ret_t;

  state_t          state;
  ret_t            ret;
  cmd_t            cmd;
  logic [W-1:0]    opa;          // product / partial remainder
  logic [W-1:0]    opb;          // multiplicand / divisor
  logic [W-1:0]    opc;          // multiplier / dividend-quotient
  logic [W-1:0]    pacc;         // power accumulator
  logic [W-1:0]    psq;          // power running square
  logic [W-1:0]    pexp;         // remaining exponent bits
  logic [CntW-1:0] cnt;
  logic [W-1:0]    res;
  logic            res_err;
  logic            res_upd;
  logic [W-1:0]    prev_result;

  logic [W-1:0] a_op, b_op, div_shift;
  logic         b_pos, a_lt_b, fin_load;
  logic [W-1:0] add_a, add_b, add_sum;
  logic         add_sub, add_carry;

  // Operand conversion from the 32-bit fields
  assign a_op      = req.use_previous ? prev_result : W'(req.left_value);
  assign b_op      = W'(req.right_value);
  assign b_pos     = (b_op != '0) && !b_op[W-1];
  assign a_lt_b    = $signed(a_op) < $signed(b_op);
  assign div_shift = {opa[W-2:0], opc[W-1]};

  assign req.ready = (state == S_IDLE);
  assign fin_load  = (state == S_FINISH) && (!rsp.valid || rsp.ready);

  // Shared unit input selection
  always_comb begin
    add_a   = a_op;
    add_b   = b_op;
    add_sub = (req.command == CMD_SUB);
    unique case (state)
      S_MUL: begin
        add_a   = opa;
        add_b   = opb;
        add_sub = 1'b0;
      end
      S_DIV: begin
        add_a   = div_shift;
        add_b   = opb;
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  aia_addsub #(.WIDTH(W)) u_addsub (
    .a     (add_a),
    .b     (add_b),
    .sub   (add_sub),
    .sum   (add_sum),
    .carry (add_carry)
  );

  // Sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp.valid   <= 1'b0;
      prev_result <= '0;
    end else begin
      // Output valid: set on load, cleared once taken
      if (fin_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd     <= req.command;
            res_err <= 1'b0;
            res_upd <= 1'b1;
            state   <= S_FINISH;
            unique case (req.command)
              CMD_ADD, CMD_SUB: res <= add_sum;
              CMD_MUL: begin
                if (b_pos) begin
                  opa   <= '0;
                  opb   <= a_op;
                  opc   <= b_op;
                  ret   <= RET_OUT;
                  state <= S_MUL;
                end else begin
                  res <= '0;
                end
              end
              CMD_DIV, CMD_MOD: begin
                if (a_lt_b) begin
                  res <= (req.command == CMD_DIV) ? '0 : a_op;
                end else if (!b_pos) begin
                  // repeated subtraction would never end
                  res     <= '0;
                  res_err <= 1'b1;
                  res_upd <= 1'b0;
                end else begin
                  opa   <= '0;
                  opb   <= b_op;
                  opc   <= a_op;
                  cnt   <= CntW'(W - 1);
                  state <= S_DIV;
                end
              end
              CMD_POW: begin
                if (b_pos) begin
                  pacc  <= W'(1);
                  psq   <= a_op;
                  pexp  <= b_op;
                  state <= S_PWR;
                end else begin
                  res <= W'(1);
                end
              end
              default: begin
                // unused codes echo the stored result
                res     <= prev_result;
                res_upd <= 1'b0;
              end
            endcase
          end
        end

        // Shift-add multiply, one multiplier bit per cycle
        S_MUL: begin
          if (opc == '0) begin
            unique case (ret)
              RET_PACC: begin
                pacc  <= opa;
                state <= S_PWR;
              end
              RET_PSQ: begin
                psq   <= opa;
                state <= S_PWR;
              end
              default: begin
                res   <= opa;
                state <= S_FINISH;
              end
            endcase
          end else begin
            if (opc[0]) opa <= add_sum;
            opb <= opb << 1;
            opc <= opc >> 1;
          end
        end

        // Restoring division, one quotient bit per cycle
        S_DIV: begin
          opa <= add_carry ? add_sum : div_shift;
          opc <= {opc[W-2:0], add_carry};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            res   <= (cmd == CMD_DIV) ? {opc[W-2:0], add_carry}
                                      : (add_carry ? add_sum : div_shift);
            state <= S_FINISH;
          end
        end

        // Square-and-multiply, exponent consumed from the low end
        S_PWR: begin
          priority if (pexp[0]) begin
            opa     <= '0;
            opb     <= pacc;
            opc     <= psq;
            ret     <= RET_PACC;
            pexp[0] <= 1'b0;
            state   <= S_MUL;
          end else if (pexp == '0) begin
            res   <= pacc;
            state <= S_FINISH;
          end else begin
            opa   <= '0;
            opb   <= psq;
            opc   <= psq;
            ret   <= RET_PSQ;
            pexp  <= pexp >> 1;
            state <= S_MUL;
          end
        end

        // Hand the result over once the output register is free
        S_FINISH: begin
          if (fin_load) begin
            rsp.result <= 32'($signed(res));
            rsp.error  <= res_err;
            if (res_upd) prev_result <= res;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `AIA_ASSERT_IMPLIES(a_err_zero, rsp.valid && rsp.error, rsp.result == '0)
  `AIA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
  `AIA_ASSERT_NEXT(a_err_keeps_prev, fin_load && res_err, prev_result == $past(prev_result))
  `AIA_ASSERT_NEXT(a_load_shows, fin_load, rsp.valid)

endmodule

[rtl/aia_addsub.sv]
// Shared adder/subtractor used by every arithmetic step of the ALU.
// Standalone; instantiated by accumulator_iterative_alu.
module aia_addsub #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] sum,
  output logic             carry
);
  logic [WIDTH-1:0] b_eff;

  // Subtract as a + ~b + 1; carry high means no borrow (a >= b unsigned)
  assign b_eff = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};
endmodule

[tb/aia_result_check.sv]
// Result checker for the accumulating iterative ALU: predicts each result and compares.
// Depends on aia_pkg, aia_req_if and aia_rsp_if; instantiated next to the DUT by the top.
module aia_result_check #(
  parameter int DataWidth = 32
) (
  input  logic clk,
  input  logic rst,
  aia_req_if   req,
  aia_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import aia_pkg::*;

  // Beyond this many mismatches only the count goes on
  localparam int MaxReports = 200;

  typedef struct packed {
    logic signed [FieldWidth-1:0] result;
    logic                         error;
  } alu_out_t;

  alu_out_t                    expected_results[$];
  alu_out_t                    want;
  logic signed [DataWidth-1:0] stored_result;

  task automatic report_mismatch(input string what, input logic [FieldWidth-1:0] got,
                                 input logic [FieldWidth-1:0] exp_val);
    if (fail_count < MaxReports) begin
      $display("%0t: %s: got %h, expected %h", $time, what, got, exp_val);
    end
    fail_count++;
  endtask

  // Result of one command; updates the stored result unless the command fails
  // or uses an unassigned code.
  function automatic alu_out_t compute_alu_result(input cmd_t cmd,
                                                  input logic signed [FieldWidth-1:0] lhs_in,
                                                  input logic signed [FieldWidth-1:0] rhs_in,
                                                  input logic chain);
    logic signed [DataWidth-1:0] lhs;
    logic signed [DataWidth-1:0] rhs;
    logic signed [DataWidth-1:0] value;
    logic        [DataWidth-1:0] pow_acc;
    logic        [DataWidth-1:0] pow_sq;
    alu_out_t                    outcome;
    lhs = chain ? stored_result : DataWidth'(lhs_in);
    rhs = DataWidth'(rhs_in);
    value = '0;
    outcome.error = 1'b0;
    case (cmd)
      CMD_ADD: value = lhs + rhs;
      CMD_SUB: value = lhs - rhs;
      // repeated addition: no iterations when the count is not positive
      CMD_MUL: value = (rhs > 0) ? lhs * rhs : '0;
      CMD_DIV, CMD_MOD: begin
        // repeated subtraction stops at once when the left side is already below
        if (lhs < rhs) begin
          value = (cmd == CMD_DIV) ? '0 : lhs;
        end else if (rhs <= 0) begin
          outcome.error = 1'b1;
        end else begin
          value = (cmd == CMD_DIV) ? lhs / rhs : lhs % rhs;
        end
      end
      CMD_POW: begin
        if (rhs > 0) begin
          pow_acc = DataWidth'(1);
          pow_sq  = lhs;
          for (int i = 0; i < DataWidth; i++) begin
            if (rhs[i]) pow_acc = pow_acc * pow_sq;
            pow_sq = pow_sq * pow_sq;
          end
          value = pow_acc;
        end else begin
          value = DataWidth'(1);
        end
      end
      default: begin
        // unassigned code: echo the stored result, state untouched
        outcome.result = FieldWidth'(stored_result);
        return outcome;
      end
    endcase
    if (outcome.error) begin
      outcome.result = '0;
    end else begin
      stored_result  = value;
      outcome.result = FieldWidth'(value);
    end
    return outcome;
  endfunction

  // Predict on every command transaction, compare on every result transaction
  always @(posedge clk) begin
    if (rst) begin
      stored_result = '0;
      fail_count    = 0;
      expected_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(compute_alu_result(req.command, req.left_value,
                                                      req.right_value, req.use_previous));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing pending", rsp.result, '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp.result !== want.result) begin
            report_mismatch("result field", rsp.result, want.result);
          end
          if (rsp.error !== want.error) begin
            report_mismatch("error flag", FieldWidth'(rsp.error), FieldWidth'(want.error));
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/tb_accumulator_iterative_alu.sv]
// Testbench top for the accumulating iterative ALU: clock, reset, stimulus, verdict.
// Depends on aia_pkg, aia_req_if, aia_rsp_if, the DUT and aia_result_check.
module tb_accumulator_iterative_alu;
  timeunit 1ns;
  timeprecision 1ps;
  import aia_pkg::*;

  localparam int DataWidth     = 32;
  localparam int RandomItems   = 1800;
  localparam int HoldOffCycles = 400;
  localparam int MaxGap        = 40;
  localparam int MaxStall      = 48;
  // Slowest command: power with a full-width exponent
  localparam int MaxOpCycles   = 2 * (DataWidth - 1) * (DataWidth + 2) + 8;
  localparam int DrainCycles   = MaxOpCycles;
  localparam int CycleLimit    =
    3 * (RandomItems + 64) * (MaxOpCycles + MaxStall + MaxGap) + 4 * HoldOffCycles;

  // Codes the block leaves unassigned
  localparam cmd_t CMD_RSVD6 = 3'd6;
  localparam cmd_t CMD_RSVD7 = 3'd7;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   hold_token;
  int   cycle_count;

  aia_req_if req_ch ();
  aia_rsp_if rsp_ch ();

  accumulator_iterative_alu #(
    .DATA_WIDTH(DataWidth)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  aia_result_check #(
    .DataWidth(DataWidth)
  ) u_result_check (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[accumulator_iterative_alu] ERROR");
    $finish;
  end

  // One command transaction; returns after the accepting edge
  task automatic send_op(input cmd_t cmd, input logic signed [FieldWidth-1:0] lhs,
                         input logic signed [FieldWidth-1:0] rhs, input logic chain);
    @(negedge clk);
    req_ch.command      <= cmd;
    req_ch.left_value   <= lhs;
    req_ch.right_value  <= rhs;
    req_ch.use_previous <= chain;
    req_ch.valid        <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Sender idle gap: drops valid and stays idle for the gap that n sets (n >= 1)
  task automatic sender_gap(input int n);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop offering and wait until every result has come back
  task automatic wait_for_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic signed [FieldWidth-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return int'($urandom_range(0, 32)) - 16;
      6: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return -32'sd1;
          3:       return 32'sd0;
          default: return 32'sd1;
        endcase
      end
      7, 8: begin
        if ($urandom_range(0, 1)) return int'($urandom_range(0, 65535));
        return -int'($urandom_range(0, 65535));
      end
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  // Receiver: ready pattern in runs of random mode, plus a counted hold-off on request
  initial begin
    int mode;
    int run;
    int hold_seen;
    hold_seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(1, MaxStall);
      repeat (run) begin
        @(negedge clk);
        if (hold_token != hold_seen) begin
          hold_seen = hold_token;
          rsp_ch.ready <= 1'b0;
          repeat (HoldOffCycles - 1) @(negedge clk);
        end else begin
          case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
          endcase
        end
      end
    end
  end

  // Stimulus
  initial begin
    int                           burst_left;
    int                           gap;
    int                           pick;
    cmd_t                         cmd;
    logic signed [FieldWidth-1:0] lhs;
    logic signed [FieldWidth-1:0] rhs;
    logic                         chain;

    hold_token          = 0;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_ADD;
    req_ch.left_value   = '0;
    req_ch.right_value  = '0;
    req_ch.use_previous = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: wrap limits, every code, special cases of divide and power
    send_op(CMD_RSVD6, 32'sd123,         32'sd5,          1'b0);
    send_op(CMD_ADD,   32'sh7FFF_FFFF,   32'sd1,          1'b0);
    send_op(CMD_SUB,   32'sh8000_0000,   32'sd1,          1'b0);
    send_op(CMD_ADD,   32'sd0,           -32'sd1,         1'b1);
    send_op(CMD_MUL,   32'sd12345,       32'sd0,          1'b0);
    send_op(CMD_MUL,   32'sd7,           32'sh8000_0000,  1'b0);
    send_op(CMD_MUL,   32'sh7FFF_FFFF,   32'sh7FFF_FFFF,  1'b0);
    send_op(CMD_MUL,   -32'sd3,          32'sd5,          1'b1);
    send_op(CMD_DIV,   32'sd5,           32'sd9,          1'b0);
    send_op(CMD_MOD,   -32'sd7,          32'sd3,          1'b0);
    send_op(CMD_DIV,   32'sd100,         32'sd7,          1'b0);
    send_op(CMD_MOD,   32'sh7FFF_FFFF,   32'sd10,         1'b0);
    // divisor not positive and left not below it: error, stored result kept
    send_op(CMD_DIV,   32'sd5,           32'sd0,          1'b0);
    send_op(CMD_MOD,   -32'sd3,          -32'sd3,         1'b0);
    send_op(CMD_DIV,   32'sh8000_0000,   32'sh8000_0000,  1'b0);
    send_op(CMD_ADD,   32'sd0,           32'sd0,          1'b1);
    send_op(CMD_MOD,   32'sh8000_0000,   32'sh7FFF_FFFF,  1'b0);
    send_op(CMD_POW,   32'sd9,           32'sd0,          1'b0);
    send_op(CMD_POW,   32'sd9,           -32'sd4,         1'b0);
    send_op(CMD_POW,   32'sd3,           32'sd5,          1'b0);
    send_op(CMD_POW,   -32'sd2,          32'sd31,         1'b0);
    send_op(CMD_POW,   32'sd3,           32'sh7FFF_FFFF,  1'b0);
    send_op(CMD_POW,   32'sd0,           32'sd1,          1'b1);
    send_op(CMD_RSVD7, 32'sh8000_0000,   32'sh7FFF_FFFF,  1'b1);
    send_op(CMD_SUB,   32'sh8000_0000,   32'sh7FFF_FFFF,  1'b1);

    // Random part in bursts
    burst_left = $urandom_range(1, 24);
    for (int k = 0; k < RandomItems; k++) begin
      if (k == RandomItems / 3) begin
        wait_for_results();
      end
      if (k == 2 * RandomItems / 3) begin
        // receiver holds off while the sender keeps offering
        hold_token++;
        burst_left = 24;
      end

      pick = $urandom_range(0, 99);
      if      (pick < 14) cmd = CMD_ADD;
      else if (pick < 28) cmd = CMD_SUB;
      else if (pick < 44) cmd = CMD_MUL;
      else if (pick < 60) cmd = CMD_DIV;
      else if (pick < 76) cmd = CMD_MOD;
      else if (pick < 94) cmd = CMD_POW;
      else                cmd = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;

      lhs   = pick_operand();
      rhs   = pick_operand();
      chain = ($urandom_range(0, 99) < 35);
      pick  = $urandom_range(0, 99);
      if (cmd == CMD_POW) begin
        // keep most exponents short, the iteration count follows their length
        if      (pick < 60) rhs = int'($urandom_range(0, 12));
        else if (pick < 75) rhs = int'($urandom_range(0, 255));
        else if (pick < 90) rhs = -(rhs & 32'h7FFF_FFFF);
        else if (pick < 97) rhs = int'($urandom_range(0, 65535));
      end else if (cmd == CMD_DIV || cmd == CMD_MOD) begin
        if (pick < 45) begin
          // ordinary quotient of two positives
          rhs = $urandom_range(0, 1) ? int'($urandom_range(1, 1000))
                                     : ($urandom & 32'h7FFF_FFFF) | 32'sd1;
          lhs = $urandom & 32'h7FFF_FFFF;
        end else if (pick < 65) begin
          // left below divisor
          rhs = int'($urandom_range(1, 1 << 30));
          lhs = rhs - int'($urandom_range(1, 1 << 30));
        end else if (pick < 85) begin
          rhs = -(rhs & 32'h7FFF_FFFF);
        end
      end

      send_op(cmd, lhs, rhs, chain);

      burst_left--;
      if (burst_left == 0) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) gap = $urandom_range(10, MaxGap);
        else if (pick == 1) gap = 0;
        else gap = $urandom_range(1, 6);
        if (gap > 0) sender_gap(gap);
        burst_left = $urandom_range(1, 24);
      end
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("[accumulator_iterative_alu] OK");
    end else begin
      $display("[accumulator_iterative_alu] ERROR");
    end
    $finish;
  end

endmodule
